// ===== rtl/pcl_pkg.sv =====
`timescale 1ns / 1ps
package pcl_pkg;
  localparam int MaxPoints  = 64;
  localparam int CoordWidth = 16;
  localparam int IdxW       = $clog2(MaxPoints);
  localparam int CntW       = IdxW + 1;
  localparam int ThrW       = 17;
  localparam int DiffW      = CoordWidth + 1;
  localparam int SqW        = 2 * DiffW;
  localparam int SumW       = SqW + 2;
  localparam int ThrSqW     = 2 * ThrW;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(256);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic [3:0] {
    StLoad, StSeed, StPop, StPopWait, StScanRd, StScanDist, StScanSq, StScanCmp,
    StOutRd, StOutWait, StOut
  } state_e;
endpackage

// ===== rtl/proximity_cluster_labeler_core.sv =====
`timescale 1ns / 1ps
// channel | valid           | stall          | payload
// in      | in_valid_i      | in_stall_o     | coord_x/y/z_i, last_point_i
// out     | out_valid_o     | out_stall_i    | point_index_o .. last_result_o
// cfg     | cfg_we_i        | -              | cfg_wdata_i
// A non-last point is stored on acceptance. On the last point a breadth-first
// visit runs: each popped point scans all N points through the point memory;
// an unvisited point passes the read, distance, square and compare states and
// a visited point only the read state. Results then leave the label memory
// through the read, wait and output states, and are held while stalled.
// Reset clears control state; memories are not cleared. Input is stalled
// from the last point until the final result beat is taken.
module proximity_cluster_labeler_core
  import pcl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [ThrW-1:0]       cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [CoordWidth-1:0] coord_x_i,
  input  logic signed [CoordWidth-1:0] coord_y_i,
  input  logic signed [CoordWidth-1:0] coord_z_i,
  input  logic                  last_point_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IdxW-1:0]       point_index_o,
  output logic [IdxW-1:0]       cluster_label_o,
  output logic [CntW-1:0]       cluster_count_o,
  output logic                  overflow_o,
  output logic                  last_result_o
);
  point_t              pmem [MaxPoints];
  logic [IdxW-1:0]     lmem [MaxPoints];
  logic [IdxW-1:0]     qmem [MaxPoints];

  state_e              state_q, state_d;
  logic [ThrW-1:0]     thr_q;
  logic [CntW-1:0]     n_q, n_d;
  logic                ovf_q, ovf_d;
  logic [MaxPoints-1:0] vis_q, vis_d;
  logic [CntW-1:0]     seed_q, seed_d, j_q, j_d, head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]     lbl_q, lbl_d, oi_q, oi_d;
  logic [IdxW-1:0]     cur_q, cur_d;
  point_t              curp_q, curp_d, pr_q;
  logic [IdxW-1:0]     qr_q, lr_q;
  logic [DiffW-1:0]    dx_q, dy_q, dz_q;
  logic [SumW-1:0]     sum_q;
  logic [ThrSqW-1:0]   thsq_q;

  logic                pwe, lwe, qwe;
  logic [IdxW-1:0]     pwa, lwa, qwa, pra, qra, lra;
  point_t              pwd;
  logic [IdxW-1:0]     lwd, qwd;
  logic                acc;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StLoad);

  always_ff @(posedge clk_i) begin
    if (pwe) pmem[pwa] <= pwd;
    if (lwe) lmem[lwa] <= lwd;
    if (qwe) qmem[qwa] <= qwd;
    pr_q <= pmem[pra];
    qr_q <= qmem[qra];
    lr_q <= lmem[lra];
  end

  function automatic logic [DiffW-1:0] absd(coord_t a, coord_t b);
    logic signed [DiffW-1:0] d;
    d = DiffW'(a) - DiffW'(b);
    return d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
  endfunction

  always_ff @(posedge clk_i) begin
    dx_q   <= absd(curp_q.x, pr_q.x);
    dy_q   <= absd(curp_q.y, pr_q.y);
    dz_q   <= absd(curp_q.z, pr_q.z);
    sum_q  <= SumW'(dx_q * dx_q) + SumW'(dy_q * dy_q) + SumW'(dz_q * dz_q);
    thsq_q <= thr_q * thr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; thr_q <= ThrReset; n_q <= '0; ovf_q <= 1'b0;
      vis_q <= '0; seed_q <= '0; j_q <= '0; head_q <= '0; tail_q <= '0;
      lbl_q <= '0; oi_q <= '0; cur_q <= '0;
    end else begin
      state_q <= state_d; n_q <= n_d; ovf_q <= ovf_d; vis_q <= vis_d;
      seed_q <= seed_d; j_q <= j_d; head_q <= head_d; tail_q <= tail_d;
      lbl_q <= lbl_d; oi_q <= oi_d; cur_q <= cur_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) curp_q <= curp_d;

  always_comb begin
    state_d = state_q; n_d = n_q; ovf_d = ovf_q; vis_d = vis_q;
    seed_d = seed_q; j_d = j_q; head_d = head_q; tail_d = tail_q;
    lbl_d = lbl_q; oi_d = oi_q; cur_d = cur_q; curp_d = curp_q;
    pwe = 1'b0; pwa = n_q[IdxW-1:0]; pwd = '{x: coord_x_i, y: coord_y_i, z: coord_z_i};
    lwe = 1'b0; lwa = cur_q; lwd = lbl_q[IdxW-1:0];
    qwe = 1'b0; qwa = tail_q[IdxW-1:0]; qwd = seed_q[IdxW-1:0];
    pra = cur_q; qra = head_q[IdxW-1:0]; lra = oi_q[IdxW-1:0];
    out_valid_o = 1'b0;
    unique case (state_q)
      StLoad: begin
        if (acc) begin
          if (n_q < CntW'(MaxPoints)) begin
            pwe = 1'b1; n_d = n_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_point_i) begin
            vis_d = '0; seed_d = '0; lbl_d = '0; state_d = StSeed;
          end
        end
      end
      StSeed: begin
        if (seed_q == n_q) begin
          oi_d = '0; state_d = StOutRd;
        end else if (vis_q[seed_q[IdxW-1:0]]) begin
          seed_d = seed_q + 1'b1;
        end else begin
          vis_d[seed_q[IdxW-1:0]] = 1'b1;
          qwe = 1'b1; qwa = '0; qwd = seed_q[IdxW-1:0];
          head_d = '0; tail_d = CntW'(1); state_d = StPop;
        end
      end
      StPop: begin
        if (head_q == tail_q) begin
          lbl_d = lbl_q + 1'b1; seed_d = seed_q + 1'b1; state_d = StSeed;
        end else begin
          state_d = StPopWait;
        end
      end
      StPopWait: begin
        cur_d = qr_q; head_d = head_q + 1'b1; j_d = '0;
        pra = qr_q; state_d = StScanRd;
      end
      StScanRd: begin
        lwe = 1'b1;
        curp_d = pr_q;
        if (j_q == n_q) begin
          state_d = StPop;
        end else if (vis_q[j_q[IdxW-1:0]]) begin
          j_d = j_q + 1'b1;
        end else begin
          pra = j_q[IdxW-1:0]; state_d = StScanDist;
        end
      end
      StScanDist: state_d = StScanSq;
      StScanSq: state_d = StScanCmp;
      StScanCmp: begin
        if (sum_q < SumW'(thsq_q)) begin
          vis_d[j_q[IdxW-1:0]] = 1'b1;
          qwe = 1'b1; qwa = tail_q[IdxW-1:0]; qwd = j_q[IdxW-1:0];
          tail_d = tail_q + 1'b1;
        end
        j_d = j_q + 1'b1; state_d = StScanRd;
      end
      StOutRd: state_d = StOutWait;
      StOutWait: state_d = StOut;
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (oi_q + 1'b1 == n_q) begin
            n_d = '0; ovf_d = 1'b0; vis_d = '0; state_d = StLoad;
          end else begin
            oi_d = oi_q + 1'b1; state_d = StOutRd;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  assign point_index_o   = oi_q[IdxW-1:0];
  assign cluster_label_o = lr_q;
  assign cluster_count_o = lbl_q;
  assign overflow_o      = ovf_q;
  assign last_result_o   = (oi_q + 1'b1 == n_q);
endmodule

// ===== rtl/pcl_checker.sv =====
`timescale 1ns / 1ps
module pcl_checker
  import pcl_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [IdxW-1:0] point_index_o,
  input logic [IdxW-1:0] cluster_label_o,
  input logic [CntW-1:0] cluster_count_o,
  input logic            last_result_o
);
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during results");
  a_label_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CntW'(cluster_label_o) < cluster_count_o))
    else $error("label beyond count");
  a_first_lbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_index_o == '0) |-> cluster_label_o == '0)
    else $error("first point not label zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(point_index_o))
    else $error("stalled beat changed");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_result_o) |=> !in_stall_o)
    else $error("input not reopened");
endmodule

bind proximity_cluster_labeler_core pcl_checker u_pcl_checker (.*);
